@@ rtl/core/rbsi_pkg.sv @@
`timescale 1ns / 1ps

package rbsi_pkg;

  localparam int OrgW  = 24;
  localparam int InvW  = 32;
  localparam int BoxW  = 16;
  localparam int TW    = 32;
  // A face offset spans face (up to 2^24) minus a signed Q16.8 origin.
  localparam int DiffW = 26;
  localparam int ProdW = InvW + DiffW;
  localparam int FracDrop = 8;

  localparam logic [BoxW-1:0]       FAR_LIMIT_RST = 16'd10000;
  localparam logic signed [TW-1:0]  MISS_T        = 32'shFFFF_0000;
  localparam logic signed [TW-1:0]  T_MAX         = 32'sh7FFF_FFFF;
  localparam logic signed [TW-1:0]  T_MIN         = 32'sh8000_0000;

  typedef struct packed {
    logic signed [OrgW-1:0] origin_x;
    logic signed [OrgW-1:0] origin_y;
    logic signed [OrgW-1:0] origin_z;
    logic signed [InvW-1:0] inv_dir_x;
    logic signed [InvW-1:0] inv_dir_y;
    logic signed [InvW-1:0] inv_dir_z;
    logic [BoxW-1:0]        box_min_x;
    logic [BoxW-1:0]        box_min_y;
    logic [BoxW-1:0]        box_min_z;
    logic [BoxW-1:0]        box_max_x;
    logic [BoxW-1:0]        box_max_y;
    logic [BoxW-1:0]        box_max_z;
  } in_item_t;

  typedef struct packed {
    logic                 hit;
    logic signed [TW-1:0] t_entry;
  } out_item_t;

  // Drop the extra fraction bits with floor and clamp to signed Q16.16.
  function automatic logic signed [TW-1:0] to_q16(input logic signed [ProdW-1:0] p);
    logic signed [ProdW-FracDrop-1:0] sh;
    logic signed [TW-1:0]             res;
    sh = p[ProdW-1:FracDrop];
    if ((&sh[ProdW-FracDrop-1:TW-1]) || !(|sh[ProdW-FracDrop-1:TW-1])) begin
      res = sh[TW-1:0];
    end else if (sh[ProdW-FracDrop-1]) begin
      res = T_MIN;
    end else begin
      res = T_MAX;
    end
    return res;
  endfunction

endpackage

@@ rtl/core/ray_box_slab_intersect.sv @@
`timescale 1ns / 1ps

// Channel | Direction | Handshake            | Payload
// in_     | input     | in_valid / in_stall  | in_data  (in_item_t)
// out_    | output    | out_valid / out_stall| out_data (out_item_t)
// cfg_    | input     | cfg_valid / cfg_ready| cfg_data (far limit, 16 bits)
//
// One ray-box test enters per cycle unless in_stall is high. Each accepted
// transaction passes through the five register stages:
// face offsets, the six 32x26 products, per-axis ordering, the entry/exit
// reduction, and the final limit compare into the output register.
// Reset clears the stage valid bits and loads the far limit with 10000.
// A stall on the output fills empty stages first; in_stall rises only when
// every stage holds a transaction.

module ray_box_slab_intersect
  import rbsi_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  in_item_t        in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output out_item_t       out_data,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [BoxW-1:0] cfg_data
);

  logic [BoxW-1:0] far_limit_r;

  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic en1, en2, en3, en4, en5;

  logic signed [DiffW-1:0] diff_lo_r [3];
  logic signed [DiffW-1:0] diff_hi_r [3];
  logic signed [InvW-1:0]  inv_r     [3];
  logic signed [DiffW-1:0] diff_lo_nxt [3];
  logic signed [DiffW-1:0] diff_hi_nxt [3];
  logic signed [InvW-1:0]  inv_nxt     [3];

  logic signed [ProdW-1:0] prod_lo_r [3];
  logic signed [ProdW-1:0] prod_hi_r [3];

  logic signed [TW-1:0] near_r   [3];
  logic signed [TW-1:0] far_r    [3];
  logic signed [TW-1:0] near_nxt [3];
  logic signed [TW-1:0] far_nxt  [3];

  logic signed [TW-1:0] tmin_r, tmax_r, tmin_nxt, tmax_nxt;
  out_item_t            out_r, out_nxt;

  logic signed [OrgW-1:0] org   [3];
  logic [BoxW-1:0]        bmin  [3];
  logic [BoxW-1:0]        bmax  [3];

  assign cfg_ready = 1'b1;

  // Each stage moves when it is empty or the stage after it moves.
  assign en5      = !v5_r || !out_stall;
  assign en4      = !v4_r || en5;
  assign en3      = !v3_r || en4;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign in_stall = !en1;

  assign org[0]  = in_data.origin_x;
  assign org[1]  = in_data.origin_y;
  assign org[2]  = in_data.origin_z;
  assign bmin[0] = in_data.box_min_x;
  assign bmin[1] = in_data.box_min_y;
  assign bmin[2] = in_data.box_min_z;
  assign bmax[0] = in_data.box_max_x;
  assign bmax[1] = in_data.box_max_y;
  assign bmax[2] = in_data.box_max_z;
  assign inv_nxt[0] = in_data.inv_dir_x;
  assign inv_nxt[1] = in_data.inv_dir_y;
  assign inv_nxt[2] = in_data.inv_dir_z;

  always_comb begin
    logic [BoxW:0] top;
    logic signed [DiffW-1:0] org_ext;
    for (int a = 0; a < 3; a++) begin
      top     = {1'b0, bmax[a]} + (BoxW+1)'(1);
      org_ext = DiffW'(org[a]);
      diff_lo_nxt[a] = $signed({2'b00, bmin[a], 8'h00}) - org_ext;
      diff_hi_nxt[a] = $signed({1'b0, top, 8'h00}) - org_ext;
    end
  end

  always_comb begin
    logic signed [TW-1:0] t1, t2;
    for (int a = 0; a < 3; a++) begin
      t1 = to_q16(prod_lo_r[a]);
      t2 = to_q16(prod_hi_r[a]);
      near_nxt[a] = (t1 < t2) ? t1 : t2;
      far_nxt[a]  = (t1 < t2) ? t2 : t1;
    end
  end

  always_comb begin
    tmin_nxt = near_r[0];
    tmax_nxt = far_r[0];
    for (int a = 1; a < 3; a++) begin
      if (near_r[a] > tmin_nxt) begin
        tmin_nxt = near_r[a];
      end
      if (far_r[a] < tmax_nxt) begin
        tmax_nxt = far_r[a];
      end
    end
  end

  always_comb begin
    logic signed [TW-1:0] lower;
    logic signed [TW:0]   limit;
    logic                 hit;
    lower = (tmin_r > 0) ? tmin_r : '0;
    limit = $signed({1'b0, far_limit_r, 16'h0000});
    hit   = (tmax_r >= lower) && ((TW+1)'(tmin_r) < limit);
    out_nxt.hit     = hit;
    out_nxt.t_entry = hit ? tmin_r : MISS_T;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      far_limit_r <= FAR_LIMIT_RST;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        far_limit_r <= cfg_data;
      end
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
      if (en5) v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      diff_lo_r <= diff_lo_nxt;
      diff_hi_r <= diff_hi_nxt;
      inv_r     <= inv_nxt;
    end
    if (en2) begin
      for (int a = 0; a < 3; a++) begin
        prod_lo_r[a] <= ProdW'(inv_r[a]) * ProdW'(diff_lo_r[a]);
        prod_hi_r[a] <= ProdW'(inv_r[a]) * ProdW'(diff_hi_r[a]);
      end
    end
    if (en3) begin
      near_r <= near_nxt;
      far_r  <= far_nxt;
    end
    if (en4) begin
      tmin_r <= tmin_nxt;
      tmax_r <= tmax_nxt;
    end
    if (en5) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = v5_r;
  assign out_data  = out_r;

  a_miss_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.hit) |-> (out_data.t_entry == MISS_T))
    else $error("miss result without the miss distance");

  a_hit_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.hit) |->
      ((TW+1)'(out_data.t_entry) < $signed({1'b0, far_limit_r, 16'h0000})))
    else $error("hit reported at or beyond the far limit");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (v1_r && v2_r && v3_r && v4_r && v5_r && out_stall))
    else $error("input stalled while the pipeline has room");

endmodule

@@ sim/tb_ray_box_slab_intersect.sv @@
`timescale 1ns / 1ps

module tb_ray_box_slab_intersect;
  import rbsi_pkg::*;

  localparam int PipeDepth  = 5;
  localparam int SettleWait = PipeDepth + 3;
  localparam int QuietLimit = 2000;
  localparam int PhaseRays  = 250;

  localparam logic [31:0] INV_ONE  = 32'h0001_0000;
  localparam logic [31:0] INV_HUGE = 32'h7FFF_FFFF;

  logic            clk       = 1'b0;
  logic            rst_n     = 1'b0;
  logic            in_valid  = 1'b0;
  logic            in_stall;
  in_item_t        in_data   = '0;
  logic            out_valid;
  logic            out_stall = 1'b0;
  out_item_t       out_data;
  logic            cfg_valid = 1'b0;
  logic            cfg_ready;
  logic [BoxW-1:0] cfg_data  = '0;

  in_item_t        pending_rays[$];
  in_item_t        directed_rays[$];
  out_item_t       expected_hits[$];
  out_item_t       oldest_hit;
  logic [BoxW-1:0] far_limit_q = FAR_LIMIT_RST;
  logic [BoxW-1:0] next_limit;

  int unsigned send_gap     = 0;
  int unsigned recv_hold    = 0;
  int unsigned quiet_cycles = 0;
  bit          send_burst   = 1'b0;
  bit          recv_burst   = 1'b0;
  bit          failed       = 1'b0;

  ray_box_slab_intersect i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Shift out the extra 8 fraction bits with floor, then clamp to signed Q16.16.
  function automatic longint floor_q16(longint prod);
    longint q;
    q = prod >>> FracDrop;
    if (q > longint'(T_MAX)) q = longint'(T_MAX);
    if (q < longint'(T_MIN)) q = longint'(T_MIN);
    return q;
  endfunction

  function automatic out_item_t slab_predict(in_item_t ray, logic [BoxW-1:0] lim);
    longint    org[3], inv[3], face_lo[3], face_hi[3];
    longint    t1, t2, t_near, t_far, t_in, t_out, lower;
    bit        is_hit;
    out_item_t res;
    org[0] = longint'($signed(ray.origin_x));
    org[1] = longint'($signed(ray.origin_y));
    org[2] = longint'($signed(ray.origin_z));
    inv[0] = longint'($signed(ray.inv_dir_x));
    inv[1] = longint'($signed(ray.inv_dir_y));
    inv[2] = longint'($signed(ray.inv_dir_z));
    face_lo[0] = longint'(ray.box_min_x) << 8;
    face_lo[1] = longint'(ray.box_min_y) << 8;
    face_lo[2] = longint'(ray.box_min_z) << 8;
    face_hi[0] = (longint'(ray.box_max_x) + 1) << 8;
    face_hi[1] = (longint'(ray.box_max_y) + 1) << 8;
    face_hi[2] = (longint'(ray.box_max_z) + 1) << 8;
    t_in  = 0;
    t_out = 0;
    for (int a = 0; a < 3; a++) begin
      t1 = floor_q16(inv[a] * (face_lo[a] - org[a]));
      t2 = floor_q16(inv[a] * (face_hi[a] - org[a]));
      t_near = (t1 < t2) ? t1 : t2;
      t_far  = (t1 < t2) ? t2 : t1;
      if (a == 0 || t_near > t_in) t_in = t_near;
      if (a == 0 || t_far < t_out) t_out = t_far;
    end
    lower  = (t_in > 0) ? t_in : 0;
    is_hit = (t_out >= lower) && (t_in < longint'(lim) * 65536);
    res.hit     = is_hit;
    res.t_entry = is_hit ? t_in[TW-1:0] : MISS_T;
    return res;
  endfunction

  function automatic in_item_t make_ray(
    input logic [31:0] ox, oy, oz, ix, iy, iz, lx, ly, lz, hx, hy, hz);
    in_item_t r;
    r.origin_x  = ox[OrgW-1:0];
    r.origin_y  = oy[OrgW-1:0];
    r.origin_z  = oz[OrgW-1:0];
    r.inv_dir_x = ix;
    r.inv_dir_y = iy;
    r.inv_dir_z = iz;
    r.box_min_x = lx[BoxW-1:0];
    r.box_min_y = ly[BoxW-1:0];
    r.box_min_z = lz[BoxW-1:0];
    r.box_max_x = hx[BoxW-1:0];
    r.box_max_y = hy[BoxW-1:0];
    r.box_max_z = hz[BoxW-1:0];
    return r;
  endfunction

  function automatic logic [31:0] extreme_value(int w);
    logic [31:0] mask;
    mask = (w == 32) ? 32'hFFFF_FFFF : (32'd1 << w) - 1;
    case ($urandom_range(0, 4))
      0: return 32'd1 << (w - 1);
      1: return (32'd1 << (w - 1)) - 1;
      2: return '0;
      3: return mask;
      default: return $urandom & mask;
    endcase
  endfunction

  function automatic in_item_t random_ray(logic [BoxW-1:0] lim);
    logic [31:0] f_org[3], f_inv[3], f_lo[3], f_hi[3];
    longint      steps, dmax, dn, lo, span, tgt;
    int unsigned kind;
    kind = $urandom_range(0, 9);
    if (kind < 6) begin
      // Aim the ray at a point inside the box, reached after a chosen number of
      // whole units. Some rays land within three units of the far limit, some start past the box.
      case ($urandom_range(0, 7))
        0, 1: steps = longint'(lim) + longint'($urandom_range(0, 6)) - 3;
        2: steps = -longint'($urandom_range(1, 50));
        default: steps = $urandom_range(0, 300);
      endcase
      dmax = (steps > 0) ? 3500000 / (steps + 1) : 1024;
      if (dmax > 1024) dmax = 1024;
      if (dmax < 1) dmax = 1;
      for (int a = 0; a < 3; a++) begin
        lo   = $urandom_range(0, 16000);
        span = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2000) : $urandom_range(0, 7);
        tgt  = (lo + longint'($urandom_range(0, span))) * 256
               + longint'($urandom_range(0, 255));
        dn   = ($urandom_range(0, 9) == 0) ? 0 : longint'($urandom_range(1, dmax));
        if ($urandom_range(0, 1) == 1) dn = -dn;
        f_inv[a] = (dn == 0) ? 32'd0 : 32'(longint'(16777216) / dn);
        f_org[a] = 32'(tgt - dn * steps);
        f_lo[a]  = 32'(lo);
        f_hi[a]  = 32'(lo + span);
      end
    end else if (kind < 8) begin
      for (int a = 0; a < 3; a++) begin
        f_org[a] = $urandom;
        f_inv[a] = $urandom;
        f_lo[a]  = $urandom;
        f_hi[a]  = $urandom;
      end
    end else begin
      for (int a = 0; a < 3; a++) begin
        f_org[a] = extreme_value(OrgW);
        f_inv[a] = extreme_value(InvW);
        f_lo[a]  = extreme_value(BoxW);
        f_hi[a]  = extreme_value(BoxW);
      end
    end
    return make_ray(f_org[0], f_org[1], f_org[2], f_inv[0], f_inv[1], f_inv[2],
                    f_lo[0], f_lo[1], f_lo[2], f_hi[0], f_hi[1], f_hi[2]);
  endfunction

  task automatic add_directed(input in_item_t r);
    directed_rays.insert(directed_rays.size(), r);
  endtask

  task automatic write_far_limit(input logic [BoxW-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid   <= 1'b0;
    far_limit_q = value;
  endtask

  // Wait until every queued ray is accepted and every result is back.
  task automatic drain_pipeline();
    do @(negedge clk); while (pending_rays.size() != 0 || in_valid || expected_hits.size() != 0);
    repeat (SettleWait) @(posedge clk);
  endtask

  // Ray driver.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_hits.insert(expected_hits.size(), slab_predict(in_data, far_limit_q));
      end
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_rays.size() != 0) begin
          in_data  <= pending_rays.pop_front();
          in_valid <= 1'b1;
          if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
          send_gap = send_burst ? 0 : $urandom_range(0, 19);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      recv_hold = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_hits.size() == 0) begin
          $error("unexpected transaction: hit %0b t_entry %h", out_data.hit, out_data.t_entry);
          failed = 1'b1;
        end else begin
          oldest_hit = expected_hits.pop_front();
          if (out_data.hit !== oldest_hit.hit) begin
            $error("hit: expected %0b, actual %0b", oldest_hit.hit, out_data.hit);
            failed = 1'b1;
          end
          if (out_data.t_entry !== oldest_hit.t_entry) begin
            $error("t_entry: expected %h, actual %h", oldest_hit.t_entry, out_data.t_entry);
            failed = 1'b1;
          end
        end
        if ($urandom_range(0, 39) == 0) recv_burst = !recv_burst;
        recv_hold = recv_burst ? 0 : $urandom_range(0, 19);
      end
      if (recv_hold > 0) begin
        out_stall <= 1'b1;
        recv_hold--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles++;
    end
  end

  initial begin
    // Hit from outside, origin inside, pointing away, all zero.
    add_directed(make_ray(-1280, 128, 128, INV_ONE, INV_HUGE, INV_HUGE,
                          0, 0, 0, 3, 0, 0));
    add_directed(make_ray(384, 128, 128, INV_ONE, INV_HUGE, INV_HUGE,
                          0, 0, 0, 3, 0, 0));
    add_directed(make_ray(-1280, 128, 128, -65536, INV_HUGE, INV_HUGE,
                          0, 0, 0, 3, 0, 0));
    add_directed(make_ray(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    // A zero reciprocal on one axis pins that axis to distance zero.
    add_directed(make_ray(-1280, 128, 128, INV_ONE, 0, INV_HUGE,
                          0, 0, 0, 3, 0, 0));
    // Inverted box on x.
    add_directed(make_ray(0, 128, 128, INV_ONE, INV_HUGE, INV_HUGE,
                          10, 0, 0, 2, 0, 0));
    // Products that saturate high and low.
    add_directed(make_ray(32'h80_0000, 32'h80_0000, 32'h80_0000,
                          INV_HUGE, INV_HUGE, INV_HUGE,
                          0, 0, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    add_directed(make_ray(32'h7F_FFFF, 32'h7F_FFFF, 32'h7F_FFFF,
                          32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                          0, 0, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    add_directed(make_ray('1, '1, '1, '1, '1, '1, '1, '1, '1, '1, '1, '1));
    // Entry exactly at the reset far limit, then one Q16.8 step short of it.
    add_directed(make_ray(-2560000, 128, 128, INV_ONE, INV_HUGE, INV_HUGE,
                          0, 0, 0, 0, 0, 0));
    add_directed(make_ray(-2559999, 128, 128, INV_ONE, INV_HUGE, INV_HUGE,
                          0, 0, 0, 0, 0, 0));
    add_directed(make_ray(1280, 128, 128, -65536, INV_HUGE, INV_HUGE,
                          0, 0, 0, 0, 0, 0));
    // Exit equals entry: the ray grazes an edge.
    add_directed(make_ray(-256, 0, 128, INV_ONE, INV_ONE, INV_HUGE,
                          0, 0, 0, 0, 0, 0));
    add_directed(make_ray(32'h7F_FFFF, 128, 128, 32'h8000_0000, INV_HUGE, INV_HUGE,
                          16'hFFFF, 0, 0, 16'hFFFF, 0, 0));

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rays[i]) pending_rays.insert(pending_rays.size(), directed_rays[i]);
    drain_pipeline();

    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: next_limit = '0;
        1: next_limit = 16'hFFFF;
        2: next_limit = 16'd1;
        3: next_limit = FAR_LIMIT_RST;
        default: next_limit = ($urandom_range(0, 1) == 1) ? BoxW'($urandom_range(0, 400))
                                                          : BoxW'($urandom_range(0, 65535));
      endcase
      write_far_limit(next_limit);
      if (phase < 2) begin
        foreach (directed_rays[i]) pending_rays.insert(pending_rays.size(), directed_rays[i]);
      end
      repeat (PhaseRays) pending_rays.insert(pending_rays.size(), random_ray(far_limit_q));
      drain_pipeline();
    end

    if (!failed) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
